[design/strip_pulse_event_classifier_unit_defines.svh]
// Assertion macros shared by the classifier RTL.
`ifndef STRIP_PULSE_EVENT_CLASSIFIER_UNIT_DEFINES_SVH
`define STRIP_PULSE_EVENT_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPEC_ASSERT_IMPLY(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPEC_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/spec_pkg.sv]
package spec_pkg;

  // Item opcodes
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADC_CUT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RUN_CUT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MULT_CUT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_CUT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDE_CUT  = 3'd4;

  localparam int unsigned CFG_BITS = 10;
  localparam int unsigned RUNC_BITS = 4;
  localparam int unsigned RUN_BITS = 5;
  localparam int unsigned CHIP_BITS = 8;
  localparam int unsigned OUT_BITS = 10;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  // Layer/axis slots: up x, up y, mid x, mid y, down x, down y
  localparam int unsigned NUM_LAYERS = 6;
  localparam logic [2:0] LAYER_UP_X   = 3'd0;
  localparam logic [2:0] LAYER_UP_Y   = 3'd1;
  localparam logic [2:0] LAYER_MID_X  = 3'd2;
  localparam logic [2:0] LAYER_MID_Y  = 3'd3;
  localparam logic [2:0] LAYER_DOWN_X = 3'd4;
  localparam logic [2:0] LAYER_DOWN_Y = 3'd5;
  localparam logic [2:0] LAYER_NONE   = 3'd7;

  typedef struct packed {
    logic [CFG_BITS-1:0]  adc_cut;
    logic [RUNC_BITS-1:0] run_cut;
    logic [CFG_BITS-1:0]  mult_cut;
    logic [CFG_BITS-1:0]  peak_cut;
    logic [CFG_BITS-1:0]  wide_cut;
  } cfg_t;

  typedef struct packed {
    logic                                is_noise;
    logic                                is_saturated;
    logic                                is_low_peak;
    logic                                is_signal;
    logic [OUT_BITS-1:0]                 event_peak;
    logic [NUM_LAYERS-1:0][OUT_BITS-1:0] counts;
  } result_t;

  // Chip id to layer/axis slot
  function automatic logic [2:0] chip_layer(input logic [CHIP_BITS-1:0] chip);
    logic [2:0] l;
    case (chip)
      8'd36, 8'd37, 8'd38, 8'd39, 8'd42, 8'd43:               l = LAYER_UP_X;
      8'd44, 8'd45, 8'd46, 8'd47:                             l = LAYER_UP_Y;
      8'd34, 8'd35, 8'd40, 8'd41, 8'd50, 8'd51:               l = LAYER_MID_X;
      8'd54, 8'd55, 8'd58, 8'd59:                             l = LAYER_MID_Y;
      8'd30, 8'd31, 8'd32, 8'd33:                             l = LAYER_DOWN_X;
      8'd48, 8'd49, 8'd52, 8'd53, 8'd56, 8'd57, 8'd60, 8'd61: l = LAYER_DOWN_Y;
      default:                                                l = LAYER_NONE;
    endcase
    return l;
  endfunction

endpackage

[design/spec_in_stage.sv]
module spec_in_stage import spec_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned BIN_BITS    = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  logic [CHIP_BITS-1:0]   chip_id,
  input  logic [BIN_BITS-1:0]    time_bin,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic                   take,
  output logic                   s_valid,
  output logic [1:0]             s_op,
  output logic [CHIP_BITS-1:0]   s_chip,
  output logic [BIN_BITS-1:0]    s_bin,
  output logic [SAMPLE_BITS-1:0] s_value
);

  logic accept;

  // Held only while the core cannot consume the buffered beat
  assign in_stall = s_valid & ~take;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (take) begin
      s_valid <= 1'b0;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      s_op    <= op;
      s_chip  <= chip_id;
      s_bin   <= time_bin;
      s_value <= sample_value;
    end
  end

endmodule

[design/spec_core.sv]
module spec_core import spec_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned BIN_BITS    = 10,
  parameter int unsigned COUNT_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   s_valid,
  input  logic [1:0]             s_op,
  input  logic [CHIP_BITS-1:0]   s_chip,
  input  logic [BIN_BITS-1:0]    s_bin,
  input  logic [SAMPLE_BITS-1:0] s_value,
  input  logic                   out_free,
  output logic                   take,
  output logic                   res_valid,
  output result_t                res
);

  localparam int unsigned SW = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
  localparam int unsigned CW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  // Channel and event state
  logic [RUN_BITS-1:0]    run_length;
  logic                   pulse_seen;
  logic [BIN_BITS-1:0]    previous_bin;
  logic [SAMPLE_BITS-1:0] segment_peak;
  logic                   channel_hit;
  logic [SAMPLE_BITS-1:0] channel_peak;
  logic [CHIP_BITS-1:0]   current_chip;
  logic [SAMPLE_BITS-1:0] peak_so_far;
  logic [COUNT_BITS-1:0]  layer_counts [NUM_LAYERS];

  logic                   hit_c;
  logic [SAMPLE_BITS-1:0] cpeak_c;
  logic [SAMPLE_BITS-1:0] peak_cl;
  logic [2:0]             layer;
  logic [COUNT_BITS-1:0]  counts_cl [NUM_LAYERS];

  logic                   brk;
  logic                   base_hit;
  logic [SAMPLE_BITS-1:0] base_cpeak;
  logic                   base_ps;
  logic [SAMPLE_BITS-1:0] base_seg;
  logic [RUN_BITS-1:0]    base_run;
  logic [SW-1:0]          v_ext;
  logic [SW-1:0]          adc_ext;
  logic [RUN_BITS-1:0]    run_new;
  logic                   ps_new;
  logic [SAMPLE_BITS-1:0] seg_new;

  logic [SW-1:0]          peak_ext;
  logic [SW-1:0]          pcut_ext;
  logic                   any_below;
  logic                   all_above;
  logic                   all_window;
  logic                   low;
  logic [CW-1:0]          c_ext;

  assign take      = s_valid & ((s_op != OP_END) | out_free);
  assign res_valid = take & (s_op == OP_END);

  // Segment commit folded into the channel
  assign hit_c   = channel_hit | pulse_seen;
  assign cpeak_c = (pulse_seen && (segment_peak > channel_peak)) ? segment_peak : channel_peak;

  // Channel close: event peak and layer count
  assign peak_cl = (hit_c && (cpeak_c > peak_so_far)) ? cpeak_c : peak_so_far;
  assign layer   = chip_layer(current_chip);
  always_comb begin
    for (int i = 0; i < NUM_LAYERS; i++) begin
      counts_cl[i] = layer_counts[i];
      if (hit_c && (layer == 3'(i)) && (layer_counts[i] != '1)) begin
        counts_cl[i] = layer_counts[i] + COUNT_BITS'(1);
      end
    end
  end

  // Sample path: continuity, run length, pulse detect
  assign brk        = ({1'b0, s_bin} + (BIN_BITS+1)'(1)) != {1'b0, previous_bin};
  assign base_hit   = brk ? hit_c : channel_hit;
  assign base_cpeak = brk ? cpeak_c : channel_peak;
  assign base_ps    = brk ? 1'b0 : pulse_seen;
  assign base_seg   = brk ? '0 : segment_peak;
  assign base_run   = brk ? '0 : run_length;
  assign v_ext      = SW'(s_value);
  assign adc_ext    = SW'(cfg.adc_cut);

  always_comb begin
    run_new = base_run;
    if (v_ext > adc_ext) begin
      if (base_run != RUN_MAX) begin
        run_new = base_run + RUN_BITS'(1);
      end
    end else if (v_ext < adc_ext) begin
      run_new = '0;
    end
  end

  assign ps_new  = base_ps | (run_new > {1'b0, cfg.run_cut});
  assign seg_new = (s_value > base_seg) ? s_value : base_seg;

  // End-of-event flags on the closed counts
  assign peak_ext = SW'(peak_cl);
  assign pcut_ext = SW'(cfg.peak_cut);
  assign low      = (peak_cl != '0) && (peak_ext < pcut_ext);

  always_comb begin
    any_below  = 1'b0;
    all_above  = 1'b1;
    all_window = 1'b1;
    res        = '0;
    c_ext      = '0;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      c_ext = CW'(counts_cl[i]);
      if (c_ext < CW'(cfg.mult_cut)) begin
        any_below = 1'b1;
      end
      if (!(c_ext > CW'(cfg.mult_cut))) begin
        all_above = 1'b0;
      end
      if (!((c_ext > CW'(cfg.mult_cut)) && (c_ext < CW'(cfg.wide_cut)))) begin
        all_window = 1'b0;
      end
      res.counts[i] = (c_ext > CW'(OUT_MAX)) ? OUT_MAX : c_ext[OUT_BITS-1:0];
    end
    res.is_noise     = any_below;
    res.is_saturated = all_above && (peak_ext > pcut_ext);
    res.is_low_peak  = low;
    res.is_signal    = low && all_window;
    res.event_peak   = (peak_ext > SW'(OUT_MAX)) ? OUT_MAX : peak_ext[OUT_BITS-1:0];
  end

  // State update, one beat per cycle whenever a beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      run_length   <= '0;
      pulse_seen   <= 1'b0;
      previous_bin <= '0;
      segment_peak <= '0;
      channel_hit  <= 1'b0;
      channel_peak <= '0;
      current_chip <= '0;
      peak_so_far  <= '0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
        layer_counts[i] <= '0;
      end
    end else if (take) begin
      unique case (s_op)
        OP_HEADER: begin
          run_length   <= '0;
          pulse_seen   <= 1'b0;
          segment_peak <= '0;
          channel_hit  <= 1'b0;
          channel_peak <= '0;
          current_chip <= s_chip;
          peak_so_far  <= peak_cl;
          layer_counts <= counts_cl;
        end
        OP_SAMPLE: begin
          run_length   <= run_new;
          pulse_seen   <= ps_new;
          segment_peak <= seg_new;
          channel_hit  <= base_hit;
          channel_peak <= base_cpeak;
          previous_bin <= s_bin;
        end
        OP_END: begin
          run_length   <= '0;
          pulse_seen   <= 1'b0;
          segment_peak <= '0;
          channel_hit  <= 1'b0;
          channel_peak <= '0;
          peak_so_far  <= '0;
          for (int i = 0; i < NUM_LAYERS; i++) begin
            layer_counts[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/spec_out_stage.sv]
module spec_out_stage import spec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    out_free,
  output result_t res_q
);

  // Room for a new result when empty or the held beat leaves now
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

endmodule

[design/strip_pulse_event_classifier_unit.sv]
// Strip pulse event classifier.
// Input channel (in_valid/in_stall) carries one beat per item: op selects a
// channel header (chip_id), a sample (time_bin, sample_value) or an end of
// event. Only end-of-event beats produce a result beat on the output channel
// (out_valid/out_stall): four class flags, the event peak and six strip counts.
// An accepted end-of-event beat passes the input register, then the result
// register. Throughput: one beat per cycle, unless an end-of-event beat
// waits in the input register for the result register to free.
// When the receiver stalls, the held result stays put; headers and samples
// keep flowing, and an end-of-event beat waits in the input register until
// the result register frees, which then stalls the input.
// Configuration: cfg_we/cfg_index/cfg_data write one threshold per cycle;
// write only while the block is idle.
// Reset (rst, synchronous) empties both registers, clears all channel and
// event state and loads the default thresholds.
`include "strip_pulse_event_classifier_unit_defines.svh"

module strip_pulse_event_classifier_unit import spec_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned BIN_BITS    = 10,
  parameter int unsigned COUNT_BITS  = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic [CHIP_BITS-1:0]    chip_id,
  input  logic [BIN_BITS-1:0]     time_bin,
  input  logic [SAMPLE_BITS-1:0]  sample_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    is_noise,
  output logic                    is_saturated,
  output logic                    is_low_peak,
  output logic                    is_signal,
  output logic [OUT_BITS-1:0]     event_peak,
  output logic [OUT_BITS-1:0]     up_x_count,
  output logic [OUT_BITS-1:0]     up_y_count,
  output logic [OUT_BITS-1:0]     mid_x_count,
  output logic [OUT_BITS-1:0]     mid_y_count,
  output logic [OUT_BITS-1:0]     down_x_count,
  output logic [OUT_BITS-1:0]     down_y_count
);

  cfg_t                   cfg;
  logic                   s_valid;
  logic [1:0]             s_op;
  logic [CHIP_BITS-1:0]   s_chip;
  logic [BIN_BITS-1:0]    s_bin;
  logic [SAMPLE_BITS-1:0] s_value;
  logic                   take;
  logic                   res_valid;
  logic                   out_free;
  result_t                res;
  result_t                res_q;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_cut   <= 10'd16;
      cfg.run_cut   <= 4'd3;
      cfg.mult_cut  <= 10'd3;
      cfg.peak_cut  <= 10'd900;
      cfg.wide_cut  <= 10'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADC_CUT:   cfg.adc_cut   <= cfg_data;
        REG_RUN_CUT:   cfg.run_cut   <= cfg_data[RUNC_BITS-1:0];
        REG_MULT_CUT:  cfg.mult_cut  <= cfg_data;
        REG_PEAK_CUT:  cfg.peak_cut  <= cfg_data;
        REG_WIDE_CUT:  cfg.wide_cut  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spec_in_stage #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .BIN_BITS   (BIN_BITS)
  ) u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .chip_id     (chip_id),
    .time_bin    (time_bin),
    .sample_value(sample_value),
    .take        (take),
    .s_valid     (s_valid),
    .s_op        (s_op),
    .s_chip      (s_chip),
    .s_bin       (s_bin),
    .s_value     (s_value)
  );

  spec_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .BIN_BITS   (BIN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_valid  (s_valid),
    .s_op     (s_op),
    .s_chip   (s_chip),
    .s_bin    (s_bin),
    .s_value  (s_value),
    .out_free (out_free),
    .take     (take),
    .res_valid(res_valid),
    .res      (res)
  );

  spec_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_free (out_free),
    .res_q    (res_q)
  );

  assign is_noise     = res_q.is_noise;
  assign is_saturated = res_q.is_saturated;
  assign is_low_peak  = res_q.is_low_peak;
  assign is_signal    = res_q.is_signal;
  assign event_peak   = res_q.event_peak;
  assign up_x_count   = res_q.counts[LAYER_UP_X];
  assign up_y_count   = res_q.counts[LAYER_UP_Y];
  assign mid_x_count  = res_q.counts[LAYER_MID_X];
  assign mid_y_count  = res_q.counts[LAYER_MID_Y];
  assign down_x_count = res_q.counts[LAYER_DOWN_X];
  assign down_y_count = res_q.counts[LAYER_DOWN_Y];

  // Checks
  `SPEC_ASSERT_IMPLY(a_stall_needs_item, clk, rst, in_stall, s_valid,
    "input stalled with empty input register")
  `SPEC_ASSERT_NEXT(a_end_gives_result, clk, rst, res_valid, out_valid,
    "end of event taken but no result shown")
  `SPEC_ASSERT_IMPLY(a_signal_is_low, clk, rst, out_valid && is_signal, is_low_peak,
    "signal flag without low-peak flag")
  `SPEC_ASSERT_IMPLY(a_sat_excl_low, clk, rst, out_valid && is_saturated, !is_low_peak,
    "saturated and low-peak flags both set")

endmodule
